[rtl/core/dvb_pkg.sv]
`timescale 1ns / 1ps

package dvb_pkg;

    localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
    localparam logic [31:0] CRC_ALL_ONES = 32'hFFFF_FFFF;

    // Blobs shorter than this cannot hold header, magic, count and checksum.
    localparam int unsigned MIN_BLOB_LEN = 20;

    localparam logic [7:0] MAGIC_PATTERN [4] = '{8'hD1, 8'hD3, 8'h39, 8'h64};

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_TOO_SHORT = 2'd1;
    localparam logic [1:0] STATUS_BAD_MAGIC = 2'd2;
    localparam logic [1:0] STATUS_BAD_CRC   = 2'd3;

    typedef struct packed {
        logic [1:0]         status;
        logic [31:0]        computed_crc;
        logic [31:0]        stored_crc;
        logic [31:0]        declared_size;
        logic signed [63:0] bitmap_count;
    } result_t;

    // One byte of the reflected CRC-32; unrolls into a flat xor network.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

[rtl/core/dvb_parser.sv]
`timescale 1ns / 1ps

module dvb_parser #(
    parameter int INDEX_WIDTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          data_byte,
    input  logic                last_byte,
    output dvb_pkg::result_t    result
);

    logic [INDEX_WIDTH-1:0] idx_reg, idx_next;
    logic [31:0]            crc_reg, crc_next;
    logic [7:0]             hold_reg [4];
    logic [7:0]             hold_next [4];
    logic [31:0]            size_reg, size_next;
    logic [63:0]            count_reg, count_next;
    logic                   magic_reg, magic_next;
    logic [31:0]            computed;
    logic [31:0]            stored;

    always_comb
    begin
        size_next  = size_reg;
        count_next = count_reg;
        magic_next = magic_reg;
        crc_next   = crc_reg;

        if (idx_reg < INDEX_WIDTH'(4))
        begin
            size_next = {size_reg[23:0], data_byte};
        end
        else if (idx_reg < INDEX_WIDTH'(8))
        begin
            if (data_byte != dvb_pkg::MAGIC_PATTERN[idx_reg[1:0]])
            begin
                magic_next = 1'b0;
            end
        end
        else if (idx_reg < INDEX_WIDTH'(16))
        begin
            count_next = count_reg | ({56'd0, data_byte} << {idx_reg[2:0], 3'b000});
        end

        // The byte leaving the hold-back sits four places behind this one.
        if (idx_reg >= INDEX_WIDTH'(8))
        begin
            crc_next = dvb_pkg::crc_byte(crc_reg, hold_reg[0]);
        end

        hold_next[0] = hold_reg[1];
        hold_next[1] = hold_reg[2];
        hold_next[2] = hold_reg[3];
        hold_next[3] = data_byte;

        idx_next = (idx_reg != '1) ? idx_reg + INDEX_WIDTH'(1) : idx_reg;

        computed = crc_next ^ dvb_pkg::CRC_ALL_ONES;
        stored   = {hold_next[0], hold_next[1], hold_next[2], hold_next[3]};

        result.computed_crc  = computed;
        result.stored_crc    = stored;
        result.declared_size = size_next;
        result.bitmap_count  = count_next;
        if (idx_next < INDEX_WIDTH'(dvb_pkg::MIN_BLOB_LEN))
        begin
            result.status = dvb_pkg::STATUS_TOO_SHORT;
        end
        else if (!magic_next)
        begin
            result.status = dvb_pkg::STATUS_BAD_MAGIC;
        end
        else if (computed != stored)
        begin
            result.status = dvb_pkg::STATUS_BAD_CRC;
        end
        else
        begin
            result.status = dvb_pkg::STATUS_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            crc_reg   <= dvb_pkg::CRC_ALL_ONES;
            hold_reg  <= '{8'd0, 8'd0, 8'd0, 8'd0};
            size_reg  <= '0;
            count_reg <= '0;
            magic_reg <= 1'b1;
        end
        else if (step)
        begin
            if (last_byte)
            begin
                // A finished blob returns the framer to its starting state.
                idx_reg   <= '0;
                crc_reg   <= dvb_pkg::CRC_ALL_ONES;
                hold_reg  <= '{8'd0, 8'd0, 8'd0, 8'd0};
                size_reg  <= '0;
                count_reg <= '0;
                magic_reg <= 1'b1;
            end
            else
            begin
                idx_reg   <= idx_next;
                crc_reg   <= crc_next;
                hold_reg  <= hold_next;
                size_reg  <= size_next;
                count_reg <= count_next;
                magic_reg <= magic_next;
            end
        end
    end

endmodule

[rtl/core/dvb_out_stage.sv]
`timescale 1ns / 1ps

module dvb_out_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  dvb_pkg::result_t   result,
    input  logic               out_stall,
    output logic               out_valid,
    output dvb_pkg::result_t   held
);

    logic             valid_reg, valid_next;
    dvb_pkg::result_t data_reg;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (valid_reg && !out_stall)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign out_valid = valid_reg;
    assign held      = data_reg;

endmodule

[rtl/core/deletion_vector_blob_checker.sv]
`timescale 1ns / 1ps

// Deletion-vector blob checker.
// Bytes of a blob arrive on the input channel (in_valid, in_stall, data_byte,
// last_byte), one transfer per byte, with last_byte set on the final byte.
// For each blob exactly one result leaves on the output channel (out_valid,
// out_stall, status, computed_crc, stored_crc, declared_size, bitmap_count).
// Each accepted byte is registered, then the framing and byte-wide CRC
// logic updates the running state; on the final byte the result is loaded
// into the output register once the last byte leaves the input register,
// and it leaves the block once the receiver does not stall.
// One byte is taken every cycle while in_stall is low; the byte-wide CRC
// update between the input register and the state registers sets that rate.
// A pending result does not block bytes of the next blob: only a final byte
// waits while the output register still holds an untaken result, and then
// in_stall rises until the receiver takes it.
// Reset clears the byte counter, CRC, hold-back and header fields, and empties
// both the input and output registers. After every final byte the framer
// returns to that same state for the next blob.

module deletion_vector_blob_checker #(
    parameter int INDEX_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         data_byte,
    input  logic               last_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic [31:0]        computed_crc,
    output logic [31:0]        stored_crc,
    output logic [31:0]        declared_size,
    output logic signed [63:0] bitmap_count
);

    logic             full_reg, full_next;
    logic [7:0]       byte_reg;
    logic             last_reg;
    logic             advance;
    logic             accept;
    dvb_pkg::result_t result;
    dvb_pkg::result_t held;

    // A registered byte moves on unless it is a final byte and the output
    // register is occupied by a result the receiver is not taking.
    assign advance  = full_reg && (!last_reg || !out_valid || !out_stall);
    assign in_stall = full_reg && !advance;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        if (accept)
        begin
            full_next = 1'b1;
        end
        else if (advance)
        begin
            full_next = 1'b0;
        end
        else
        begin
            full_next = full_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= data_byte;
            last_reg <= last_byte;
        end
    end

    dvb_parser #(
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .data_byte (byte_reg),
        .last_byte (last_reg),
        .result    (result)
    );

    dvb_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && last_reg),
        .result    (result),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .held      (held)
    );

    assign status        = held.status;
    assign computed_crc  = held.computed_crc;
    assign stored_crc    = held.stored_crc;
    assign declared_size = held.declared_size;
    assign bitmap_count  = held.bitmap_count;

endmodule

[bench/blob_result_checker.sv]
`timescale 1ns / 1ps

module blob_result_checker #(
    parameter int INDEX_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [7:0]         data_byte,
    input  logic               last_byte,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [1:0]         status,
    input  logic [31:0]        computed_crc,
    input  logic [31:0]        stored_crc,
    input  logic [31:0]        declared_size,
    input  logic signed [63:0] bitmap_count,
    output int                 mismatches,
    output int                 pending_results
);

    logic [INDEX_WIDTH-1:0] byte_pos;
    logic [31:0]            crc_run;
    logic [7:0]             tail [4];
    logic [31:0]            size_acc;
    logic [63:0]            count_acc;
    logic                   magic_ok;
    dvb_pkg::result_t       awaited_results [$];
    dvb_pkg::result_t       want;
    int                     failures;

    function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ dvb_pkg::CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic void clear_frame();
        byte_pos  = '0;
        crc_run   = dvb_pkg::CRC_ALL_ONES;
        tail      = '{default: 8'h00};
        size_acc  = '0;
        count_acc = '0;
        magic_ok  = 1'b1;
    endfunction

    // Predicts the framer for one accepted byte and queues a result on the final one.
    function automatic void absorb_byte(input logic [7:0] b, input logic fin);
        dvb_pkg::result_t       r;
        logic [INDEX_WIDTH-1:0] idx;
        idx = byte_pos;
        if (idx < 4)
        begin
            size_acc = {size_acc[23:0], b};
        end
        else if (idx < 8)
        begin
            if (b != dvb_pkg::MAGIC_PATTERN[idx - 4])
            begin
                magic_ok = 1'b0;
            end
        end
        else if (idx < 16)
        begin
            count_acc |= 64'(b) << {idx[2:0], 3'b000};
        end
        // The byte leaving the hold-back is four places behind, never a checksum byte.
        if (idx >= 8)
        begin
            crc_run = crc_step(crc_run, tail[0]);
        end
        tail[0] = tail[1];
        tail[1] = tail[2];
        tail[2] = tail[3];
        tail[3] = b;
        if (byte_pos != '1)
        begin
            byte_pos++;
        end
        if (fin)
        begin
            r.computed_crc  = crc_run ^ dvb_pkg::CRC_ALL_ONES;
            r.stored_crc    = {tail[0], tail[1], tail[2], tail[3]};
            r.declared_size = size_acc;
            r.bitmap_count  = count_acc;
            if (byte_pos < dvb_pkg::MIN_BLOB_LEN)
            begin
                r.status = dvb_pkg::STATUS_TOO_SHORT;
            end
            else if (!magic_ok)
            begin
                r.status = dvb_pkg::STATUS_BAD_MAGIC;
            end
            else if (r.computed_crc != r.stored_crc)
            begin
                r.status = dvb_pkg::STATUS_BAD_CRC;
            end
            else
            begin
                r.status = dvb_pkg::STATUS_OK;
            end
            awaited_results.push_back(r);
            clear_frame();
        end
    endfunction

    function automatic void compare_field(input string fname, input logic [63:0] exp_v,
                                          input logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            if (failures < 10)
            begin
                $display("mismatch in %s: expected %h, got %h", fname, exp_v, act_v);
            end
            failures++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_frame();
            awaited_results.delete();
            failures        = 0;
            mismatches      <= 0;
            pending_results <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                absorb_byte(data_byte, last_byte);
            end
            if (out_valid && !out_stall)
            begin
                if (awaited_results.size() == 0)
                begin
                    if (failures < 10)
                    begin
                        $display("unexpected result: status %0d crc %h/%h size %h count %h",
                                 status, computed_crc, stored_crc, declared_size, bitmap_count);
                    end
                    failures++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    compare_field("status", 64'(want.status), 64'(status));
                    compare_field("computed_crc", 64'(want.computed_crc), 64'(computed_crc));
                    compare_field("stored_crc", 64'(want.stored_crc), 64'(stored_crc));
                    compare_field("declared_size", 64'(want.declared_size),
                                  64'(declared_size));
                    compare_field("bitmap_count", want.bitmap_count, bitmap_count);
                end
            end
            mismatches      <= failures;
            pending_results <= awaited_results.size();
        end
    end

endmodule

[bench/deletion_vector_blob_checker_tb.sv]
`timescale 1ns / 1ps

// The top of the bench only makes stimulus and gives the verdict. The checker
// instance beside the block watches both channels, predicts every result and
// counts the mismatches.
module deletion_vector_blob_checker_tb;

    // A byte counter narrower than the block's default.
    localparam int INDEX_WIDTH  = 16;
    localparam int QUIET_LIMIT  = 2000;
    localparam int LONG_HOLD    = 150;
    localparam int RANDOM_BYTES = 600;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [7:0]         data_byte;
    logic               last_byte;
    logic               out_valid;
    logic               out_stall;
    logic [1:0]         status;
    logic [31:0]        computed_crc;
    logic [31:0]        stored_crc;
    logic [31:0]        declared_size;
    logic signed [63:0] bitmap_count;

    int mismatches;
    int pending_results;

    // Idle controls set by the stimulus and read by the sending and receiving processes.
    bit src_idle;
    bit sink_idle;
    bit hold_request;

    // The blob that is about to be sent, first byte at index 0.
    logic [7:0] blob [$];

    deletion_vector_blob_checker #(
        .INDEX_WIDTH(INDEX_WIDTH)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .computed_crc (computed_crc),
        .stored_crc   (stored_crc),
        .declared_size(declared_size),
        .bitmap_count (bitmap_count)
    );

    blob_result_checker #(
        .INDEX_WIDTH(INDEX_WIDTH)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_byte      (data_byte),
        .last_byte      (last_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .computed_crc   (computed_crc),
        .stored_crc     (stored_crc),
        .declared_size  (declared_size),
        .bitmap_count   (bitmap_count),
        .mismatches     (mismatches),
        .pending_results(pending_results)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // The stimulus needs a valid checksum to build well-formed blobs, so the
    // generator carries its own byte-wide CRC-32.
    function automatic logic [31:0] crc_feed(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ dvb_pkg::CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // Builds a complete blob: size, magic, count, body_len random body bytes
    // and the checksum. Set bits of magic_flip corrupt the matching magic byte
    // before the checksum is taken, so only the magic test can fail.
    function automatic void frame_blob(input logic [31:0] size, input logic [63:0] count,
                                       input int body_len, input logic [3:0] magic_flip);
        logic [31:0] crc;
        blob.delete();
        for (int i = 3; i >= 0; i--)
        begin
            blob.push_back(size[8*i +: 8]);
        end
        for (int k = 0; k < 4; k++)
        begin
            blob.push_back(dvb_pkg::MAGIC_PATTERN[k] ^ (magic_flip[k]
                                                        ? 8'($urandom_range(1, 255))
                                                        : 8'h00));
        end
        for (int i = 0; i < 8; i++)
        begin
            blob.push_back(count[8*i +: 8]);
        end
        repeat (body_len)
        begin
            blob.push_back(8'($urandom_range(0, 255)));
        end
        crc = dvb_pkg::CRC_ALL_ONES;
        for (int i = 4; i < blob.size(); i++)
        begin
            crc = crc_feed(crc, blob[i]);
        end
        crc ^= dvb_pkg::CRC_ALL_ONES;
        for (int i = 3; i >= 0; i--)
        begin
            blob.push_back(crc[8*i +: 8]);
        end
    endfunction

    // Flips one bit somewhere in the four checksum bytes.
    function automatic void spoil_checksum();
        blob[blob.size() - 1 - $urandom_range(0, 3)] ^= 8'(1 << $urandom_range(0, 7));
    endfunction

    function automatic void trim_blob(input int keep);
        while (blob.size() > keep)
        begin
            void'(blob.pop_back());
        end
    endfunction

    // One byte transfer. A random idle burst may come first; the payload is
    // then held until the block takes it.
    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        gap = (src_idle && $urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : 0;
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid  <= 1'b1;
        data_byte <= b;
        last_byte <= fin;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
    endtask

    task automatic send_blob();
        for (int i = 0; i < blob.size(); i++)
        begin
            send_byte(blob[i], i == blob.size() - 1);
        end
    endtask

    // Receiver: random stall bursts while sink_idle is set, and one long
    // hold-off on request so that a pending result backs up the input.
    initial
    begin : receiver
        int burst;
        int hold_left;
        burst     = 0;
        hold_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_left    = LONG_HOLD;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (burst > 0)
            begin
                burst--;
                out_stall <= 1'b1;
            end
            else if (sink_idle && $urandom_range(0, 5) == 0)
            begin
                burst = $urandom_range(1, 6) - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog: ends the run if neither channel moves for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        wait (rst_n === 1'b1);
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("** deletion_vector_blob_checker: FAILED **");
        $finish;
    end

    initial
    begin : stimulus
        int       random_sent;
        int       pick;
        int       body_len;
        bit       quiet_tail;
        int       short_lens [5];
        logic [31:0] size;
        logic [63:0] count;

        in_valid     = 1'b0;
        data_byte    = 8'h00;
        last_byte    = 1'b0;
        rst_n        = 1'b0;
        src_idle     = 1'b1;
        sink_idle    = 1'b1;
        hold_request = 1'b0;
        short_lens   = '{4, 8, 12, 16, 19};
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed blobs. The minimum well-formed blob has no body at all, and
        // the header fields go to their extremes.
        frame_blob(32'h0000_0000, 64'h0000_0000_0000_0000, 0, 4'b0000);
        send_blob();
        frame_blob(32'hFFFF_FFFF, 64'h8000_0000_0000_0000, 0, 4'b0000);
        send_blob();
        frame_blob(32'h0102_0304, 64'h7FFF_FFFF_FFFF_FFFF, 3, 4'b0000);
        send_blob();
        frame_blob(32'h8000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 1, 4'b0000);
        send_blob();

        // A wrong byte in each magic position in turn.
        for (int k = 0; k < 4; k++)
        begin
            frame_blob($urandom, {$urandom, $urandom}, 2, 4'(1 << k));
            send_blob();
        end

        // A checksum mismatch, and then a bad magic that must win over one.
        frame_blob($urandom, {$urandom, $urandom}, 5, 4'b0000);
        spoil_checksum();
        send_blob();
        frame_blob($urandom, {$urandom, $urandom}, 4, 4'b1111);
        spoil_checksum();
        send_blob();

        // Short blobs: a single byte, then cuts at every header boundary and
        // one byte short of the minimum. The 12-byte cut also has a bad magic,
        // which must still report as too short.
        blob.delete();
        blob.push_back(8'hFF);
        send_blob();
        foreach (short_lens[i])
        begin
            frame_blob($urandom, {$urandom, $urandom}, 0,
                       (short_lens[i] == 12) ? 4'b0010 : 4'b0000);
            trim_blob(short_lens[i]);
            send_blob();
        end

        // Twenty zero bytes pass the length test but fail the magic.
        blob.delete();
        repeat (20) blob.push_back(8'h00);
        send_blob();

        // Back-pressure: the receiver holds off while minimum-size blobs keep
        // coming, so the second final byte has to wait at the input.
        src_idle     = 1'b0;
        sink_idle    = 1'b0;
        hold_request = 1'b1;
        repeat (6)
        begin
            frame_blob($urandom, {$urandom, $urandom}, 0, 4'b0000);
            send_blob();
        end

        // Random blobs, mostly well-formed with random content. The last
        // fifth runs with no idling on either side.
        random_sent = 0;
        while (random_sent < RANDOM_BYTES)
        begin
            quiet_tail = random_sent >= (RANDOM_BYTES * 4) / 5;
            src_idle   = !quiet_tail && ($urandom_range(0, 3) != 0);
            sink_idle  = !quiet_tail && ($urandom_range(0, 3) != 0);
            pick       = $urandom_range(0, 9);
            size       = $urandom;
            count      = {$urandom, $urandom};
            if ($urandom_range(0, 7) == 0)
            begin
                count = $urandom_range(0, 1) ? 64'h8000_0000_0000_0000
                                             : 64'h7FFF_FFFF_FFFF_FFFF;
            end
            body_len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64)
                                                   : $urandom_range(0, 16);
            if (pick < 7)
            begin
                frame_blob(size, count, body_len, 4'b0000);
            end
            else if (pick == 7)
            begin
                frame_blob(size, count, body_len, 4'($urandom_range(1, 15)));
            end
            else if (pick == 8)
            begin
                frame_blob(size, count, body_len, 4'b0000);
                spoil_checksum();
            end
            else
            begin
                // Noise: random bytes of random length.
                blob.delete();
                repeat ($urandom_range(1, 40)) blob.push_back(8'($urandom_range(0, 255)));
            end
            send_blob();
            random_sent += blob.size();
        end

        @(negedge clk);
        in_valid <= 1'b0;

        // Drain: every predicted result must arrive, and a few more cycles
        // give a spurious extra result the chance to show up.
        while (pending_results != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);

        if (mismatches == 0 && pending_results == 0)
        begin
            $display("** deletion_vector_blob_checker: PASSED **");
        end
        else
        begin
            $display("** deletion_vector_blob_checker: FAILED **");
        end
        $finish;
    end

endmodule

[files.f]
rtl/core/dvb_pkg.sv
rtl/core/dvb_parser.sv
rtl/core/dvb_out_stage.sv
rtl/core/deletion_vector_blob_checker.sv
bench/blob_result_checker.sv
bench/deletion_vector_blob_checker_tb.sv
